[src/spbc_pkg.sv]
// ----------------------------------------------------------------------------
// spbc_pkg: shared types, constants and round functions
// Beat formats, register indexes, status codes and the 16-bit SP function.
// ----------------------------------------------------------------------------
package spbc_pkg;

  localparam int OUT_DEPTH   = 4;
  localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
  localparam int OUT_LEVEL_W = OUT_PTR_W + 1;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_CIPHER_KEY = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SBOX_TABLE = 1'b1;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_SHORT_MSG  = 2'd1;
  localparam logic [1:0] STATUS_SHORT_ITEM = 2'd2;

  localparam logic [2:0] FULL_BYTES = 3'd4;

  typedef struct packed {
    logic [31:0] plain_word;
    logic [2:0]  byte_count;
    logic        is_final;
  } item_t;

  typedef struct packed {
    logic [31:0] cipher_word;
    logic [2:0]  valid_bytes;
    logic        end_of_message;
    logic [1:0]  status;
  } result_t;

  // up to two result beats written into the output queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // key mix, nibble S-box, then bit i (MSB = 0) moves to (5i+9) mod 16
  function automatic logic [15:0] sp_func(input logic [15:0] x, input logic [15:0] k,
                                          input logic [63:0] sbox);
    logic [15:0] v;
    logic [15:0] s;
    logic [15:0] p;
    logic [3:0]  nib;
    v = x ^ k;
    s = '0;
    for (int n = 0; n < 4; n++) begin
      nib = v[4*n +: 4];
      s[4*n +: 4] = sbox[{nib, 2'b00} +: 4];
    end
    p = '0;
    for (int i = 0; i < 16; i++) begin
      p[15 - ((5 * i + 9) % 16)] = s[15 - i];
    end
    return p;
  endfunction

  // high bytes that belong to the message for a byte count
  function automatic logic [31:0] keep_mask(input logic [2:0] cnt);
    logic [31:0] m;
    unique case (cnt)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'hFF00_0000;
      3'd2:    m = 32'hFFFF_0000;
      3'd3:    m = 32'hFFFF_FF00;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

[src/spbc_encrypt.sv]
// ----------------------------------------------------------------------------
// spbc_encrypt: four-round block transform
// Two Lai-Massey rounds then two Feistel rounds on one 32-bit block.
// ----------------------------------------------------------------------------
module spbc_encrypt
  import spbc_pkg::*;
(
  input  logic [31:0] blk,
  input  logic [31:0] cipher_key,
  input  logic [63:0] sbox_table,
  output logic [31:0] enc
);

  logic [15:0] key_hi, key_lo;
  logic [15:0] l0, r0, f1, l1, r1, f2, l2, r2, l3, l4;

  assign key_hi = cipher_key[31:16];
  assign key_lo = cipher_key[15:0];
  assign l0     = blk[31:16];
  assign r0     = blk[15:0];

  // Lai-Massey rounds
  assign f1 = sp_func(l0 ^ r0, key_hi, sbox_table);
  assign l1 = l0 ^ f1;
  assign r1 = r0 ^ f1;
  assign f2 = sp_func(l1 ^ r1, key_lo, sbox_table);
  assign l2 = l1 ^ f2;
  assign r2 = r1 ^ f2;

  // Feistel rounds
  assign l3 = sp_func(l2, key_hi, sbox_table) ^ r2;
  assign l4 = sp_func(l3, key_lo, sbox_table) ^ l2;

  assign enc = {l4, l3};

endmodule

[src/spbc_out_queue.sv]
// ----------------------------------------------------------------------------
// spbc_out_queue: result queue
// Takes up to two result beats a cycle, hands out one beat a cycle.
// ----------------------------------------------------------------------------
module spbc_out_queue
  import spbc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  push_t                  push,
  input  logic                   pop,
  output logic                   head_valid,
  output result_t                head,
  output logic [OUT_LEVEL_W-1:0] level
);

  result_t                entries [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [OUT_PTR_W-1:0]   wr_ptr_second;
  logic [OUT_LEVEL_W-1:0] level_next;

  assign wr_ptr_second = wr_ptr + OUT_PTR_W'(1);
  assign level_next    = level + OUT_LEVEL_W'(push.count) - OUT_LEVEL_W'(pop);
  assign head_valid    = (level != '0);
  assign head          = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_second] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OUT_PTR_W'(push.count);
      rd_ptr <= rd_ptr + OUT_PTR_W'(pop);
      level  <= level_next;
    end
  end

endmodule

[src/sp_block_cipher_with_stealing_top.sv]
// ----------------------------------------------------------------------------
// sp_block_cipher_with_stealing_top: 32-bit block cipher with stealing
// Input register, four-round encrypt, held block and a result queue.
// ----------------------------------------------------------------------------
// Takes one plaintext word per clock while item_stall is low. A word is
// registered, encrypted in the following cycle by the four unrolled rounds
// and its results (zero, one or two beats) are written to a four-entry queue
// when the word advances. The queue drains one beat per cycle while
// result_stall is low, so a full non-final word sustains one word per cycle,
// while a word that produces two beats (a full final word behind a held block,
// or a stolen short block) fills two entries. The input stalls only when the
// registered word cannot move because the queue has fewer than two free
// entries. Each full block is held back one word so that a short final
// block can steal bytes from it. Key and S-box writes take effect at once
// and belong only between messages, while the block is idle.
module sp_block_cipher_with_stealing_top
  import spbc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [31:0]            cipher_key;
  logic [63:0]            sbox_table;
  logic                   s1_valid;
  item_t                  s1;
  logic [31:0]            held_block, held_block_next;
  logic                   held_valid, held_valid_next;
  logic                   advance, accept, pop;
  logic                   full, fin;
  logic [31:0]            mask, enc_in, enc_out;
  push_t                  push_req, push;
  logic [OUT_LEVEL_W-1:0] level;

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= '0;
      sbox_table <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CIPHER_KEY: cipher_key <= cfg_data[31:0];
        REG_SBOX_TABLE: sbox_table <= cfg_data;
      endcase
    end
  end

  // ---- input register ----
  assign advance    = s1_valid && (level <= OUT_LEVEL_W'(OUT_DEPTH - 2));
  assign item_stall = s1_valid && !advance;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= item;
    end
  end

  // ---- encrypt ----
  // counts above four act as a full word
  assign full   = (s1.byte_count >= FULL_BYTES);
  assign fin    = s1.is_final;
  assign mask   = keep_mask(s1.byte_count);
  // short final block borrows the tail of the held block
  assign enc_in = full ? s1.plain_word
                       : ((s1.plain_word & mask) | (held_block & ~mask));

  spbc_encrypt u_encrypt (
    .blk        (enc_in),
    .cipher_key (cipher_key),
    .sbox_table (sbox_table),
    .enc        (enc_out)
  );

  // ---- result selection and held block ----
  always_comb begin
    push_req        = '0;
    held_block_next = held_block;
    held_valid_next = held_valid;
    priority if (full) begin
      if (held_valid) begin
        push_req.first = '{held_block, FULL_BYTES, 1'b0, STATUS_OK};
        if (fin) begin
          push_req.second = '{enc_out, FULL_BYTES, 1'b1, STATUS_OK};
          push_req.count  = 2'd2;
        end else begin
          push_req.count = 2'd1;
        end
      end else if (fin) begin
        push_req.first = '{enc_out, FULL_BYTES, 1'b1, STATUS_OK};
        push_req.count = 2'd1;
      end
      if (fin) begin
        held_block_next = '0;
        held_valid_next = 1'b0;
      end else begin
        held_block_next = enc_out;
        held_valid_next = 1'b1;
      end
    end else if (!fin) begin
      push_req.first = '{32'd0, 3'd0, 1'b0, STATUS_SHORT_ITEM};
      push_req.count = 2'd1;
    end else if (!held_valid) begin
      push_req.first = '{32'd0, 3'd0, 1'b1, STATUS_SHORT_MSG};
      push_req.count = 2'd1;
    end else begin
      if (s1.byte_count == 3'd0) begin
        push_req.first = '{held_block, FULL_BYTES, 1'b1, STATUS_OK};
        push_req.count = 2'd1;
      end else begin
        push_req.first  = '{enc_out, FULL_BYTES, 1'b0, STATUS_OK};
        push_req.second = '{held_block & mask, s1.byte_count, 1'b1, STATUS_OK};
        push_req.count  = 2'd2;
      end
      held_block_next = '0;
      held_valid_next = 1'b0;
    end
  end

  always_comb begin
    push = push_req;
    if (!advance) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_block <= '0;
      held_valid <= 1'b0;
    end else if (advance) begin
      held_block <= held_block_next;
      held_valid <= held_valid_next;
    end
  end

  // ---- result queue ----
  assign pop = result_valid && !result_stall;

  spbc_out_queue u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .head_valid (result_valid),
    .head       (result),
    .level      (level)
  );

  // ---- assertions ----
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    level <= OUT_LEVEL_W'(OUT_DEPTH))
    else $error("result queue overflow");

  a_double_needs_held: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> held_valid)
    else $error("two result beats without a held block");

  a_final_releases_held: assert property (@(posedge clk) disable iff (rst)
    (advance && s1.is_final) |=> !held_valid)
    else $error("held block survives a final word");

  a_push_only_on_advance: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> s1_valid)
    else $error("result pushed without a registered word");

endmodule
